FILE: sv/pde_pkg.sv
// Shared types, sizes and codes of the point distance engine.
`default_nettype none
package pde_pkg;

    // Store geometry and coordinate format.
    localparam int MAX_POINTS = 256;
    localparam int MAX_DIMS   = 64;
    localparam int COORD_BITS = 16;

    localparam int POINT_W = $clog2(MAX_POINTS);
    localparam int ADDR_W  = $clog2(MAX_POINTS * MAX_DIMS);
    localparam int CNT_W   = $clog2(MAX_DIMS + 1);
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int SQ_W    = 2 * COORD_BITS;

    // Result width and the square root built on it.
    localparam int DIST_W  = 38;
    localparam int ROOT_W  = DIST_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int STEP_W  = $clog2(ROOT_W + 1);

    // Field widths of the request and configuration ports.
    localparam int CFG_W   = 7;
    localparam int METRIC_W = 2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic REG_METRIC = 1'b0;
    localparam logic REG_DIMS   = 1'b1;

    localparam logic [METRIC_W-1:0] METRIC_EUCLID  = 2'd0;
    localparam logic [METRIC_W-1:0] METRIC_SQUARED = 2'd1;

    localparam logic [CFG_W-1:0] DIMS_RESET = 7'd64;

    typedef struct packed {
        logic               func;
        logic [7:0]         point_a;
        logic [7:0]         point_b;
        logic [5:0]         coord_index;
        logic signed [15:0] coord_value;
    } pde_in_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              metric_invalid;
    } pde_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_ROOT,
        ST_OUT
    } pde_state_t;

endpackage
`default_nettype wire

FILE: sv/pde_store.sv
// Coordinate store: one write port and two registered read ports.
`default_nettype none
module pde_store (
    input  wire logic                             aclk,
    input  wire logic                             we,
    input  wire logic [pde_pkg::ADDR_W-1:0]       waddr,
    input  wire logic [pde_pkg::COORD_BITS-1:0]   wdata,
    input  wire logic [pde_pkg::ADDR_W-1:0]       raddr_a,
    input  wire logic [pde_pkg::ADDR_W-1:0]       raddr_b,
    output logic      [pde_pkg::COORD_BITS-1:0]   rdata_a,
    output logic      [pde_pkg::COORD_BITS-1:0]   rdata_b
);

    logic [pde_pkg::COORD_BITS-1:0] mem [pde_pkg::MAX_POINTS * pde_pkg::MAX_DIMS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

FILE: sv/pde_isqrt.sv
// Iterative floor square root, one result bit per cycle.
`default_nettype none
module pde_isqrt (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [pde_pkg::DIST_W-1:0]   radicand,
    output logic                              done,
    output logic      [pde_pkg::ROOT_W-1:0]   root
);

    logic [pde_pkg::DIST_W-1:0] rad_reg;
    logic [pde_pkg::REM_W-1:0]  rem_reg;
    logic [pde_pkg::ROOT_W-1:0] root_reg;
    logic [pde_pkg::STEP_W-1:0] step_reg;
    logic                       done_reg;

    logic [pde_pkg::REM_W-1:0]  rem_sh;
    logic [pde_pkg::REM_W-1:0]  trial;
    logic                       fits;

    // Bring down the next two radicand bits and try appending a one to the root.
    assign rem_sh = {rem_reg[pde_pkg::REM_W-3:0], rad_reg[pde_pkg::DIST_W-1 -: 2]};
    assign trial  = pde_pkg::REM_W'({root_reg, 2'b01});
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                step_reg <= pde_pkg::STEP_W'(pde_pkg::ROOT_W);
            end else if (step_reg != '0) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == pde_pkg::STEP_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (step_reg != '0) begin
            rad_reg <= {rad_reg[pde_pkg::DIST_W-3:0], 2'b00};
            if (fits) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[pde_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[pde_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

FILE: sv/point_distance_engine_unit.sv
// Top level of the point distance engine: request decode, sum sequencer and result register.
`default_nettype none
// A write request stores one signed coordinate into the on-chip point store; the block is
// ready again right after it. A query request reads the two points one coordinate pair per
// cycle from the store's two read ports and then, in euclidean mode, waits for the floor
// square root, which produces one result bit per cycle. An unknown metric skips the sum and
// answers with distance zero and metric_invalid set. The result sits in an output register,
// so the next request is taken while a result still waits. The store is not cleared at
// reset: a query must only touch coordinates that were written before.
module point_distance_engine_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [pde_pkg::CFG_W-1:0]   cfg_wdata,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire pde_pkg::pde_in_t            s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output pde_pkg::pde_out_t                m_data
);

    pde_pkg::pde_state_t state_reg, state_next;

    logic [pde_pkg::METRIC_W-1:0] metric_reg;
    logic [pde_pkg::CFG_W-1:0]    dims_reg;

    logic [pde_pkg::ADDR_W-1:0]   base_a_reg, base_b_reg;
    logic [pde_pkg::CNT_W-1:0]    idx_reg, n_reg;
    logic                         rd_vld_reg, prod_vld_reg;
    logic [pde_pkg::SQ_W-1:0]     prod_reg;
    logic [pde_pkg::DIST_W-1:0]   acc_reg, acc_next;
    logic [pde_pkg::DIST_W-1:0]   dist_reg;
    logic                         invalid_reg;
    logic                         m_valid_reg;
    pde_pkg::pde_out_t            m_data_reg;

    logic                         in_take, take_query, metric_bad;
    logic                         mem_we, issue, sum_end, sq_start, load_out;
    logic [pde_pkg::ADDR_W-1:0]   waddr;
    logic [pde_pkg::COORD_BITS-1:0] rdata_a, rdata_b;
    logic signed [pde_pkg::DIFF_W-1:0] diff;
    logic signed [2*pde_pkg::DIFF_W-1:0] sq_full;
    logic                         sq_done;
    logic [pde_pkg::ROOT_W-1:0]   root;
    logic [pde_pkg::POINT_W-1:0]  pa, pb;
    logic [pde_pkg::CNT_W-1:0]    n_sat;
    logic                         ci_ok;

    assign metric_bad = !(metric_reg == pde_pkg::METRIC_EUCLID ||
                          metric_reg == pde_pkg::METRIC_SQUARED);

    // Point numbers wrap modulo the store size, which is a power of two.
    assign pa = s_data.point_a[pde_pkg::POINT_W-1:0];
    assign pb = s_data.point_b[pde_pkg::POINT_W-1:0];
    assign ci_ok = (32'(s_data.coord_index) < pde_pkg::MAX_DIMS);
    assign n_sat = (32'(dims_reg) > pde_pkg::MAX_DIMS) ?
                   pde_pkg::CNT_W'(pde_pkg::MAX_DIMS) : pde_pkg::CNT_W'(dims_reg);

    assign waddr = pde_pkg::ADDR_W'(pa) * pde_pkg::ADDR_W'(pde_pkg::MAX_DIMS)
                 + pde_pkg::ADDR_W'(s_data.coord_index);

    assign in_take    = s_valid && s_ready;
    assign take_query = in_take && (s_data.func == pde_pkg::FUNC_QUERY);
    assign sum_end    = (idx_reg == n_reg) && !rd_vld_reg && !prod_vld_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pde_pkg::ST_IDLE: begin
                if (take_query) begin
                    state_next = metric_bad ? pde_pkg::ST_OUT : pde_pkg::ST_SUM;
                end
            end
            pde_pkg::ST_SUM: begin
                if (sum_end) begin
                    state_next = (metric_reg == pde_pkg::METRIC_EUCLID) ?
                                 pde_pkg::ST_ROOT : pde_pkg::ST_OUT;
                end
            end
            pde_pkg::ST_ROOT: begin
                if (sq_done) begin
                    state_next = pde_pkg::ST_OUT;
                end
            end
            pde_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = pde_pkg::ST_IDLE;
                end
            end
            default: state_next = pde_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        s_ready  = 1'b0;
        mem_we   = 1'b0;
        issue    = 1'b0;
        sq_start = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            pde_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                mem_we  = in_take && (s_data.func == pde_pkg::FUNC_WRITE) && ci_ok;
            end
            pde_pkg::ST_SUM: begin
                issue    = (idx_reg != n_reg);
                sq_start = sum_end && (metric_reg == pde_pkg::METRIC_EUCLID);
            end
            pde_pkg::ST_ROOT: begin
            end
            pde_pkg::ST_OUT: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= pde_pkg::ST_IDLE;
            metric_reg <= pde_pkg::METRIC_EUCLID;
            dims_reg   <= pde_pkg::DIMS_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    pde_pkg::REG_METRIC: metric_reg <= cfg_wdata[pde_pkg::METRIC_W-1:0];
                    pde_pkg::REG_DIMS:   dims_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    pde_store u_store (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (waddr),
        .wdata   (s_data.coord_value[pde_pkg::COORD_BITS-1:0]),
        .raddr_a (base_a_reg + pde_pkg::ADDR_W'(idx_reg)),
        .raddr_b (base_b_reg + pde_pkg::ADDR_W'(idx_reg)),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Difference and square of the pair that came out of the store this cycle.
    assign diff    = pde_pkg::DIFF_W'($signed(rdata_b)) - pde_pkg::DIFF_W'($signed(rdata_a));
    assign sq_full = (2*pde_pkg::DIFF_W)'(diff) * (2*pde_pkg::DIFF_W)'(diff);

    assign acc_next = prod_vld_reg ? acc_reg + pde_pkg::DIST_W'(prod_reg) : acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            n_reg        <= '0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
            if (take_query) begin
                idx_reg <= '0;
                n_reg   <= n_sat;
            end else if (issue) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= sq_full[pde_pkg::SQ_W-1:0];
        if (take_query) begin
            base_a_reg  <= pde_pkg::ADDR_W'(pa) * pde_pkg::ADDR_W'(pde_pkg::MAX_DIMS);
            base_b_reg  <= pde_pkg::ADDR_W'(pb) * pde_pkg::ADDR_W'(pde_pkg::MAX_DIMS);
            acc_reg     <= '0;
            dist_reg    <= '0;
            invalid_reg <= metric_bad;
        end else begin
            acc_reg <= acc_next;
            if (state_reg == pde_pkg::ST_SUM && sum_end) begin
                dist_reg <= acc_reg;
            end else if (sq_done) begin
                dist_reg <= pde_pkg::DIST_W'(root);
            end
        end
    end

    pde_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (acc_reg),
        .done     (sq_done),
        .root     (root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg.distance       <= dist_reg;
            m_data_reg.metric_invalid <= invalid_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_prod_in_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        prod_vld_reg |-> state_reg == pde_pkg::ST_SUM)
        else $error("product arrived outside the summing phase");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pde_pkg::ST_SUM |-> idx_reg <= n_reg)
        else $error("coordinate index ran past the dimension count");

    a_root_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_done |-> state_reg == pde_pkg::ST_ROOT)
        else $error("square root finished while no query waited for it");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid_reg || m_ready))
        else $error("result register loaded over a pending result");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> state_reg == pde_pkg::ST_IDLE)
        else $error("sequencer did not return to idle after loading a result");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb_point_distance_engine_unit.sv
// Self-checking testbench for the point distance engine: directed cases and random traffic.
module tb_point_distance_engine_unit;
    import pde_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 100;
    localparam longint CYCLE_LIMIT = 1500000;

    localparam logic [METRIC_W-1:0] METRIC_BAD_LO = 2'd2;
    localparam logic [METRIC_W-1:0] METRIC_BAD_HI = 2'd3;

    typedef enum {FILL_LOW, FILL_HIGH, FILL_MIXED} fill_kind_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic              cfg_index = REG_METRIC;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    pde_in_t           s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    pde_out_t          m_data;

    // Shadow copy of the point store and of the two registers.
    shortint           coord_store [MAX_POINTS][MAX_DIMS];
    bit [MAX_DIMS-1:0] coord_written [MAX_POINTS];
    logic [METRIC_W-1:0] metric_reg = METRIC_EUCLID;
    logic [CFG_W-1:0]  dims_reg = DIMS_RESET;

    pde_out_t          pending_distances [$];
    pde_out_t          expected_result;
    int                fail_count = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    longint            cycle_count = 0;

    point_distance_engine_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b1;
        #HALF_PERIOD;
        aclk = 1'b0;
        #HALF_PERIOD;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int active_dims();
        return (dims_reg > MAX_DIMS) ? MAX_DIMS : int'(dims_reg);
    endfunction

    function automatic bit [MAX_DIMS-1:0] needed_coords(input int eff);
        return (eff >= MAX_DIMS) ? '1 : ((64'd1 << eff) - 64'd1);
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int b = ROOT_W; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= x) root = cand;
        end
        return root;
    endfunction

    function automatic pde_out_t predict_distance(input logic [7:0] pa, input logic [7:0] pb);
        pde_out_t        res;
        longint unsigned acc;
        longint          diff;
        acc = 0;
        res = '0;
        for (int i = 0; i < active_dims(); i++) begin
            diff = longint'(coord_store[pb][i]) - longint'(coord_store[pa][i]);
            acc += longint'(diff * diff);
        end
        case (metric_reg)
            METRIC_EUCLID: res.distance = DIST_W'(floor_root(acc));
            METRIC_SQUARED: res.distance = DIST_W'(acc);
            default: res.metric_invalid = 1'b1;
        endcase
        return res;
    endfunction

    // Called once per accepted request; queries queue their expected distance.
    function automatic void record_request(input pde_in_t req);
        if (req.func == FUNC_WRITE) begin
            coord_store[req.point_a][req.coord_index] = req.coord_value;
            coord_written[req.point_a][req.coord_index] = 1'b1;
        end else begin
            pending_distances.push_back(predict_distance(req.point_a, req.point_b));
        end
    endfunction

    function automatic logic signed [15:0] random_coord();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'($urandom_range(16)) - 16'sd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic pde_in_t make_write(input int p, input int c, input logic signed [15:0] v);
        pde_in_t req;
        req.func        = FUNC_WRITE;
        req.point_a     = 8'(p);
        req.point_b     = 8'($urandom);
        req.coord_index = 6'(c);
        req.coord_value = v;
        return req;
    endfunction

    function automatic pde_in_t make_query(input int a, input int b);
        pde_in_t req;
        req.func        = FUNC_QUERY;
        req.point_a     = 8'(a);
        req.point_b     = 8'(b);
        req.coord_index = 6'($urandom);
        req.coord_value = 16'($urandom);
        return req;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_distances.size() == 0) begin
                fail_count++;
                $display("%0t: result with no query waiting: distance=%0d invalid=%0b",
                         $time, m_data.distance, m_data.metric_invalid);
            end else begin
                expected_result = pending_distances.pop_front();
                if (m_data.distance !== expected_result.distance) begin
                    fail_count++;
                    $display("%0t: distance mismatch: expected %0d, actual %0d",
                             $time, expected_result.distance, m_data.distance);
                end
                if (m_data.metric_invalid !== expected_result.metric_invalid) begin
                    fail_count++;
                    $display("%0t: metric_invalid mismatch: expected %0b, actual %0b",
                             $time, expected_result.metric_invalid, m_data.metric_invalid);
                end
            end
        end
    end

    task automatic send_request(input pde_in_t req);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        record_request(req);
    endtask

    // Lets every outstanding result drain, then gives a write time to settle.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_distances.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        wait_idle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_METRIC) metric_reg = val[METRIC_W-1:0];
        else dims_reg = val;
    endtask

    task automatic send_random_query(output bit sent);
        int              pool [$];
        bit [MAX_DIMS-1:0] need;
        int              a;
        int              b;
        sent = 1'b0;
        need = needed_coords(active_dims());
        for (int p = 0; p < MAX_POINTS; p++) begin
            if ((coord_written[p] & need) == need) pool.push_back(p);
        end
        if (pool.size() == 0) return;
        a = pool[$urandom_range(pool.size() - 1)];
        b = ($urandom_range(7) == 0) ? a : pool[$urandom_range(pool.size() - 1)];
        send_request(make_query(a, b));
        sent = 1'b1;
    endtask

    // Writes every active coordinate of one random point, preferably one not yet fully written.
    task automatic fill_point(input fill_kind_t kind);
        int                  p;
        int                  tries;
        int                  eff;
        bit [MAX_DIMS-1:0]   need;
        logic signed [15:0]  v;
        eff   = active_dims();
        need  = needed_coords(eff);
        tries = 0;
        p     = $urandom_range(MAX_POINTS - 1);
        while ((coord_written[p] & need) == need && tries < 20) begin
            p = $urandom_range(MAX_POINTS - 1);
            tries++;
        end
        for (int c = 0; c < eff; c++) begin
            case (kind)
                FILL_LOW: v = 16'sh8000;
                FILL_HIGH: v = 16'sh7FFF;
                default: v = random_coord();
            endcase
            send_request(make_write(p, c, v));
        end
    endtask

    task automatic test_squared_extremes();
        write_reg(REG_METRIC, CFG_W'(METRIC_SQUARED));
        write_reg(REG_DIMS, 7'd1);
        send_request(make_write(0, 0, 16'sh8000));
        send_request(make_write(255, 0, 16'sh7FFF));
        send_request(make_write(170, 0, 16'sh5555));
        send_request(make_write(85, 0, 16'shAAAA));
        send_request(make_write(0, 63, 16'sd1));
        send_request(make_write(255, 63, -16'sd1));
        send_request(make_query(0, 255));
        send_request(make_query(255, 0));
        // The same point on both sides must give zero.
        send_request(make_query(0, 0));
        send_request(make_query(170, 85));
    endtask

    task automatic test_euclidean();
        write_reg(REG_METRIC, CFG_W'(METRIC_EUCLID));
        send_request(make_query(0, 255));
        send_request(make_query(170, 85));
        send_request(make_query(85, 85));
    endtask

    task automatic test_unknown_metric();
        write_reg(REG_METRIC, CFG_W'(METRIC_BAD_LO));
        send_request(make_query(0, 255));
        write_reg(REG_METRIC, CFG_W'(METRIC_BAD_HI));
        send_request(make_query(170, 85));
    endtask

    task automatic test_zero_dims();
        write_reg(REG_METRIC, CFG_W'(METRIC_SQUARED));
        write_reg(REG_DIMS, 7'd0);
        // With no dimensions nothing is read, so unwritten points are allowed here.
        send_request(make_query(3, 200));
        send_request(make_query(0, 255));
    endtask

    task automatic test_dims_saturate();
        bit sent;
        write_reg(REG_METRIC, CFG_W'(METRIC_SQUARED));
        write_reg(REG_DIMS, 7'd127);
        send_random_query(sent);
        send_random_query(sent);
        write_reg(REG_METRIC, CFG_W'(METRIC_EUCLID));
        write_reg(REG_DIMS, 7'd65);
        send_random_query(sent);
        send_random_query(sent);
    endtask

    task automatic test_random_traffic(input logic [METRIC_W-1:0] metric, input int dims,
                                       input int send_idle, input int recv_stall,
                                       input int n_items, input int n_fill);
        logic [CFG_W-1:0] mval;
        bit               sent;
        int               eff;
        int               p;
        int               c;
        // Upper data bits on a metric write are ignored by the register.
        mval = CFG_W'($urandom);
        mval[METRIC_W-1:0] = metric;
        write_reg(REG_METRIC, mval);
        write_reg(REG_DIMS, CFG_W'(dims));
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        eff = active_dims();
        for (int f = 0; f < n_fill && eff > 0; f++) begin
            fill_point(f == 0 ? FILL_LOW : (f == 1 ? FILL_HIGH : FILL_MIXED));
        end
        for (int i = 0; i < n_items; i++) begin
            sent = 1'b0;
            if ($urandom_range(99) < 50) send_random_query(sent);
            if (!sent) begin
                p = $urandom_range(MAX_POINTS - 1);
                c = (eff > 0 && $urandom_range(1) == 1) ? $urandom_range(eff - 1)
                                                        : $urandom_range(MAX_DIMS - 1);
                send_request(make_write(p, c, random_coord()));
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_squared_extremes();
        test_euclidean();
        test_unknown_metric();
        test_zero_dims();
        test_random_traffic(METRIC_SQUARED, 64, 0, 0, 150, 4);
        test_dims_saturate();
        test_random_traffic(METRIC_EUCLID, 64, 47, 0, 150, 1);
        test_random_traffic(METRIC_EUCLID, 127, 0, 47, 100, 0);
        test_random_traffic(METRIC_SQUARED, 5, 25, 25, 150, 6);
        test_random_traffic(METRIC_EUCLID, 1, 0, 0, 150, 3);
        test_random_traffic(METRIC_BAD_LO, 13, 47, 0, 100, 2);
        test_random_traffic(METRIC_BAD_HI, 64, 0, 47, 80, 0);
        test_random_traffic(METRIC_SQUARED, 0, 25, 25, 100, 0);
        test_random_traffic(METRIC_EUCLID, 40, 0, 0, 150, 2);
        test_random_traffic(METRIC_SQUARED, 100, 47, 0, 150, 0);
        test_random_traffic(METRIC_EUCLID, 17, 25, 25, 120, 2);

        wait_idle();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
